@@ sv/efs_pkg.sv @@
`timescale 1ns / 1ps

package efs_pkg;

    localparam int QUEUE_DEPTH = 32;

    localparam logic [1:0] CMD_POST     = 2'd0;
    localparam logic [1:0] CMD_DISPATCH = 2'd1;
    localparam logic [1:0] CMD_CLEAR    = 2'd2;
    localparam logic [1:0] CMD_STATUS   = 2'd3;

    localparam logic [1:0] KIND_POST   = 2'd0;
    localparam logic [1:0] KIND_EVENT  = 2'd1;
    localparam logic [1:0] KIND_EMPTY  = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    localparam logic [5:0] MAX_RESULTS = 6'd32;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] handler;
        logic [31:0] context_word;
        logic [31:0] event_value;
        logic [5:0]  max_events;
    } efs_in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        accepted;
        logic [31:0] out_handler;
        logic [31:0] out_context;
        logic [31:0] out_value;
        logic        last;
        logic [5:0]  pending;
        logic [5:0]  peak;
        logic [31:0] dropped;
    } efs_out_t;

    typedef struct packed {
        logic [31:0] handler;
        logic [31:0] context_word;
        logic [31:0] event_value;
    } efs_entry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } efs_cell_ctrl_t;

endpackage

@@ sv/efs_cell.sv @@
`timescale 1ns / 1ps

module efs_cell #(
    parameter int CELL_IDX = 0,
    parameter int CNT_W    = 6
) (
    input  logic                  aclk,
    input  efs_pkg::efs_cell_ctrl_t ctrl,
    input  logic [CNT_W-1:0]      count,
    input  efs_pkg::efs_entry_t   push_entry,
    input  efs_pkg::efs_entry_t   shift_in,
    output efs_pkg::efs_entry_t   entry_out
);
    import efs_pkg::*;

    efs_entry_t entry_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.pop) begin
            entry_reg <= shift_in;
        end else if (ctrl.push && (count == CNT_W'(CELL_IDX))) begin
            entry_reg <= push_entry;
        end
    end

    assign entry_out = entry_reg;

endmodule

@@ sv/event_fifo_with_stats.sv @@
`timescale 1ns / 1ps
// Bounded event queue with drop and high-water statistics.
// Input channel s_valid/s_ready/s_data carries one command word: post,
// dispatch, clear statistics or status query. Result channel
// m_valid/m_ready/m_data carries result words through an output register.
// A post, clear or status command yields one word.
// A dispatch yields one word per popped entry, one per cycle while the
// receiver takes them, so it holds the input channel until its last entry
// is popped (1 to 32 entries); a dispatch that pops nothing yields one word.
// Entries live in a row of QUEUE_DEPTH cells; the head is cell 0 and a pop
// shifts every entry one place toward the head, all cells together.
// An accepted command's first result word is registered and valid in the next cycle.
// Reset empties the queue and clears the drop count and the high-water mark.
// When the receiver stalls, the current word holds in the output register
// and no new command is taken until that register can be reloaded.
module event_fifo_with_stats (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  efs_pkg::efs_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output efs_pkg::efs_out_t m_data
);
    import efs_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DISP = 1'b1;

    logic             state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] peak_reg, peak_next;
    logic [31:0]      drop_reg, drop_next;
    logic [5:0]       rem_reg, rem_next;
    logic             m_valid_reg, m_valid_next;
    efs_out_t         m_data_reg, m_data_next;

    efs_entry_t       entries [QUEUE_DEPTH];
    efs_entry_t       push_entry;
    efs_cell_ctrl_t   ctrl;
    logic             out_free;
    logic             in_fire;
    logic             load_out;
    logic [5:0]       lim;
    logic [5:0]       pop_n;

    assign out_free   = !m_valid_reg || m_ready;
    assign s_ready    = (state_reg == ST_IDLE) && out_free;
    assign in_fire    = s_valid && s_ready;
    assign push_entry = '{handler: s_data.handler, context_word: s_data.context_word,
                          event_value: s_data.event_value};

    always_comb begin
        lim = (s_data.max_events > MAX_RESULTS) ? MAX_RESULTS : s_data.max_events;
        if (CMP_W'(count_reg) < CMP_W'(lim)) begin
            pop_n = 6'(count_reg);
        end else begin
            pop_n = lim;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            efs_cell #(
                .CELL_IDX (gi),
                .CNT_W    (CNT_W)
            ) u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .count      (count_reg),
                .push_entry (push_entry),
                .shift_in   (entries[(gi + 1 < QUEUE_DEPTH) ? gi + 1 : gi]),
                .entry_out  (entries[gi])
            );
        end
    endgenerate

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        peak_next   = peak_reg;
        drop_next   = drop_reg;
        rem_next    = rem_reg;
        ctrl        = '{push: 1'b0, pop: 1'b0};
        load_out    = 1'b0;
        m_data_next = '0;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    load_out = 1'b1;
                    m_data_next.last = 1'b1;
                    case (s_data.cmd)
                        CMD_POST: begin
                            m_data_next.kind = KIND_POST;
                            if (s_data.handler != 32'd0) begin
                                if (count_reg == CNT_W'(QUEUE_DEPTH)) begin
                                    drop_next = drop_reg + 32'd1;
                                end else begin
                                    ctrl.push = 1'b1;
                                    count_next = count_reg + CNT_W'(1);
                                    if (count_next > peak_reg) begin
                                        peak_next = count_next;
                                    end
                                    m_data_next.accepted = 1'b1;
                                end
                            end
                        end
                        CMD_DISPATCH: begin
                            if (pop_n == 6'd0) begin
                                m_data_next.kind = KIND_EMPTY;
                            end else begin
                                ctrl.pop = 1'b1;
                                count_next = count_reg - CNT_W'(1);
                                m_data_next.kind = KIND_EVENT;
                                m_data_next.out_handler = entries[0].handler;
                                m_data_next.out_context = entries[0].context_word;
                                m_data_next.out_value = entries[0].event_value;
                                m_data_next.last = (pop_n == 6'd1);
                                rem_next = pop_n - 6'd1;
                                if (pop_n != 6'd1) begin
                                    state_next = ST_DISP;
                                end
                            end
                        end
                        CMD_CLEAR: begin
                            m_data_next.kind = KIND_STATUS;
                            drop_next = 32'd0;
                            peak_next = count_reg;
                        end
                        default: begin
                            m_data_next.kind = KIND_STATUS;
                        end
                    endcase
                end
            end
            ST_DISP: begin
                if (out_free) begin
                    load_out = 1'b1;
                    ctrl.pop = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                    rem_next = rem_reg - 6'd1;
                    m_data_next.kind = KIND_EVENT;
                    m_data_next.out_handler = entries[0].handler;
                    m_data_next.out_context = entries[0].context_word;
                    m_data_next.out_value = entries[0].event_value;
                    m_data_next.last = (rem_reg == 6'd1);
                    if (rem_reg == 6'd1) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        m_data_next.pending = 6'(count_next);
        m_data_next.peak    = 6'(peak_next);
        m_data_next.dropped = drop_next;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            peak_reg    <= '0;
            drop_reg    <= '0;
            rem_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            peak_reg    <= peak_next;
            drop_reg    <= drop_next;
            rem_reg     <= rem_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("Queue count exceeds depth.");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.pop |-> count_reg != '0)
        else $error("Pop from an empty queue.");

    a_disp_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DISP |-> (rem_reg != 6'd0) && (CMP_W'(rem_reg) <= CMP_W'(count_reg)))
        else $error("Dispatch remainder out of range.");

    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.push |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("Push did not advance the count.");

    a_peak_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        peak_reg >= count_reg)
        else $error("High-water mark below occupancy.");

endmodule

@@ tb/efs_checker.sv @@
`timescale 1ns / 1ps

module efs_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  efs_pkg::efs_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  efs_pkg::efs_out_t m_data,
    output int                fail_count,
    output int                words_due
);
    import efs_pkg::*;

    localparam int DEPTH = 32;

    logic [31:0] slot_handler [DEPTH];
    logic [31:0] slot_context [DEPTH];
    logic [31:0] slot_value   [DEPTH];
    logic [4:0]  wr_ptr;
    logic [4:0]  rd_ptr;
    logic [5:0]  fill_level;
    logic [5:0]  high_mark;
    logic [31:0] drop_count;
    efs_out_t    due_words [$];
    int          errors;

    assign fail_count = errors;

    function automatic efs_out_t make_word(input logic [1:0] kind, input logic acc,
                                           input logic [31:0] h, input logic [31:0] c,
                                           input logic [31:0] v, input logic lst);
        efs_out_t w;
        w.kind        = kind;
        w.accepted    = acc;
        w.out_handler = h;
        w.out_context = c;
        w.out_value   = v;
        w.last        = lst;
        w.pending     = fill_level;
        w.peak        = high_mark;
        w.dropped     = drop_count;
        return w;
    endfunction

    task automatic predict_cmd(input efs_in_t cmd_word);
        int         n;
        logic       acc;
        logic [4:0] r;
        case (cmd_word.cmd)
            CMD_POST: begin
                acc = 1'b0;
                if (cmd_word.handler != 32'd0) begin
                    if (fill_level < 6'(DEPTH)) begin
                        slot_handler[wr_ptr] = cmd_word.handler;
                        slot_context[wr_ptr] = cmd_word.context_word;
                        slot_value[wr_ptr]   = cmd_word.event_value;
                        wr_ptr               = wr_ptr + 5'd1;
                        fill_level           = fill_level + 6'd1;
                        if (fill_level > high_mark) begin
                            high_mark = fill_level;
                        end
                        acc = 1'b1;
                    end else begin
                        drop_count = drop_count + 32'd1;
                    end
                end
                due_words.push_back(make_word(KIND_POST, acc, '0, '0, '0, 1'b1));
            end
            CMD_DISPATCH: begin
                n = int'(cmd_word.max_events);
                if (n > int'(fill_level)) begin
                    n = int'(fill_level);
                end
                if (n > int'(MAX_RESULTS)) begin
                    n = int'(MAX_RESULTS);
                end
                if (n == 0) begin
                    due_words.push_back(make_word(KIND_EMPTY, 1'b0, '0, '0, '0, 1'b1));
                end
                for (int i = 0; i < n; i++) begin
                    r          = rd_ptr;
                    rd_ptr     = rd_ptr + 5'd1;
                    fill_level = fill_level - 6'd1;
                    due_words.push_back(make_word(KIND_EVENT, 1'b0, slot_handler[r],
                                                  slot_context[r], slot_value[r],
                                                  i == n - 1));
                end
            end
            default: begin
                if (cmd_word.cmd == CMD_CLEAR) begin
                    drop_count = 32'd0;
                    high_mark  = fill_level;
                end
                due_words.push_back(make_word(KIND_STATUS, 1'b0, '0, '0, '0, 1'b1));
            end
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        $display("efs_checker: %s at %0t", msg, $time);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    task automatic check_word(input efs_out_t got);
        efs_out_t want;
        if (due_words.size() == 0) begin
            report_mismatch($sformatf("word %0h with nothing expected", got));
        end else begin
            want = due_words.pop_front();
            check_field("kind", 32'(got.kind), 32'(want.kind));
            check_field("accepted", 32'(got.accepted), 32'(want.accepted));
            check_field("out_handler", got.out_handler, want.out_handler);
            check_field("out_context", got.out_context, want.out_context);
            check_field("out_value", got.out_value, want.out_value);
            check_field("last", 32'(got.last), 32'(want.last));
            check_field("pending", 32'(got.pending), 32'(want.pending));
            check_field("peak", 32'(got.peak), 32'(want.peak));
            check_field("dropped", got.dropped, want.dropped);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr     = '0;
            rd_ptr     = '0;
            fill_level = '0;
            high_mark  = '0;
            drop_count = '0;
            errors     = 0;
            due_words.delete();
        end else begin
            if (s_valid && s_ready) begin
                predict_cmd(s_data);
            end
            if (m_valid && m_ready) begin
                check_word(m_data);
            end
        end
        words_due <= due_words.size();
    end

endmodule

@@ tb/event_fifo_with_stats_tb.sv @@
`timescale 1ns / 1ps

module event_fifo_with_stats_tb;

    import efs_pkg::*;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    efs_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    efs_out_t m_data;
    int       fail_count;
    int       words_due;
    bit       steady  = 1'b0;
    int       sent;

    always #6 aclk = ~aclk;

    event_fifo_with_stats uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    efs_checker checker_inst (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .fail_count (fail_count),
        .words_due  (words_due)
    );

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 11);
    end

    function automatic efs_in_t make_cmd(input logic [1:0] cmd, input logic [31:0] h,
                                         input logic [31:0] c, input logic [31:0] v,
                                         input logic [5:0] maxe);
        efs_in_t w;
        w.cmd          = cmd;
        w.handler      = h;
        w.context_word = c;
        w.event_value  = v;
        w.max_events   = maxe;
        return w;
    endfunction

    function automatic logic [31:0] pick_handler();
        case ($urandom_range(0, 11))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'd1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [5:0] pick_max_events();
        case ($urandom_range(0, 7))
            0:       return 6'd32;
            1, 2:    return 6'($urandom_range(0, 32));
            default: return 6'($urandom_range(0, 8));
        endcase
    endfunction

    task automatic send_word(input efs_in_t w);
        while (!steady && $urandom_range(0, 99) < 11) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (words_due != 0);
    endtask

    task automatic send_random(input int mode);
        int          roll;
        logic [1:0]  cmd;
        roll = $urandom_range(0, 99);
        case (mode)
            0:       cmd = (roll < 95) ? CMD_POST : CMD_STATUS;
            1:       cmd = (roll < 50) ? CMD_POST : (roll < 80) ? CMD_DISPATCH :
                           (roll < 88) ? CMD_CLEAR : CMD_STATUS;
            2:       cmd = (roll < 30) ? CMD_POST : (roll < 85) ? CMD_DISPATCH :
                           (roll < 90) ? CMD_CLEAR : CMD_STATUS;
            default: cmd = 2'($urandom_range(0, 3));
        endcase
        send_word(make_cmd(cmd, pick_handler(), $urandom(), $urandom(), pick_max_events()));
    endtask

    initial begin
        int mode;
        int len;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        send_word(make_cmd(CMD_STATUS, '0, '0, '0, '0));
        send_word(make_cmd(CMD_DISPATCH, '0, '0, '0, 6'd5));
        send_word(make_cmd(CMD_POST, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63));
        send_word(make_cmd(CMD_POST, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 6'd0));
        send_word(make_cmd(CMD_POST, 32'd1, 32'hFFFF_FFFF, 32'd0, 6'd32));
        send_word(make_cmd(CMD_DISPATCH, '1, '1, '1, 6'd0));
        send_word(make_cmd(CMD_CLEAR, '1, '1, '1, '1));
        send_word(make_cmd(CMD_DISPATCH, '0, '0, '0, 6'd32));
        for (int i = 0; i < 33; i++) begin
            send_word(make_cmd(CMD_POST, $urandom() | 32'd1, $urandom(), $urandom(),
                               6'($urandom_range(0, 63))));
        end
        send_word(make_cmd(CMD_POST, 32'd0, $urandom(), $urandom(), '0));
        send_word(make_cmd(CMD_STATUS, '0, '0, '0, '0));
        send_word(make_cmd(CMD_DISPATCH, '0, '0, '0, 6'd32));
        drain_results();
        send_word(make_cmd(CMD_CLEAR, '0, '0, '0, '0));
        send_word(make_cmd(CMD_STATUS, '0, '0, '0, '0));

        sent = 0;
        while (sent < 405) begin
            mode = $urandom_range(0, 3);
            len  = $urandom_range(10, 40);
            for (int i = 0; i < len && sent < 405; i++) begin
                steady = (sent >= 150 && sent < 230);
                if (sent == 300) begin
                    drain_results();
                end
                send_random(mode);
                sent++;
            end
        end
        steady = 1'b0;

        drain_results();
        repeat (40) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
